// ===== rtl/core/tan_pkg.sv =====
// shared constants for the triangle area and unit normal block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tan_pkg;

    localparam int COORD_BITS_DEF  = 24;
    localparam int NORMAL_BITS_DEF = 16;
    localparam int AREA_BITS       = 51;
    localparam int SQ_BITS         = 128;
    localparam int ROOT_BITS       = 64;
    localparam int REM_BITS        = 66;
    localparam int K_BITS          = 6;
    localparam int NORM_STEPS      = 6;
    localparam int FRONT_STAGES    = 6;

endpackage

`default_nettype wire

// ===== rtl/core/tan_in_if.sv =====
// input channel: one triangle, three vertices in signed fixed point
// depends on tan_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tan_in_if
    import tan_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF
);
    logic          valid;
    logic          ready;
    logic signed [CB-1:0] a_x;
    logic signed [CB-1:0] a_y;
    logic signed [CB-1:0] a_z;
    logic signed [CB-1:0] b_x;
    logic signed [CB-1:0] b_y;
    logic signed [CB-1:0] b_z;
    logic signed [CB-1:0] c_x;
    logic signed [CB-1:0] c_y;
    logic signed [CB-1:0] c_z;

    modport source (
        output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        input  ready
    );

    modport sink (
        input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/tan_out_if.sv =====
// result channel: area, unit normal and degenerate flag
// depends on tan_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tan_out_if
    import tan_pkg::*;
#(
    parameter int NB = NORMAL_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [AREA_BITS-1:0] area;
    logic signed [NB-1:0] unit_x;
    logic signed [NB-1:0] unit_y;
    logic signed [NB-1:0] unit_z;
    logic                 degenerate;

    modport source (
        output valid, area, unit_x, unit_y, unit_z, degenerate,
        input  ready
    );

    modport sink (
        input  valid, area, unit_x, unit_y, unit_z, degenerate,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/triangle_area_and_normal.sv =====
// top level: triangle area and unit face normal, fully pipelined
// depends on tan_pkg, tan_in_if, tan_out_if, tan_front, tan_norm, tan_sqrt_cell, tan_div_cell
//
//   channel   dir  payload                                    transfer
//   tri_in    in   a_x..c_z, COORD_BITS signed each           valid & ready
//   res_out   out  area, unit_x/y/z, degenerate               valid & ready
//
// one triangle per cycle while the pipe advances; the stages, in order:
// 6 front stages, 6 shift stages, 64 square root cells, 1 stage, NORMAL_BITS+1
// divide cells and the output register
// the whole pipe advances when the output register is empty or taken;
// tri_in.ready follows that same enable
// reset clears only the valid bits
`timescale 1ns / 1ps
`default_nettype none

module triangle_area_and_normal
    import tan_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int NORMAL_BITS = NORMAL_BITS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    tan_in_if.sink    tri_in,
    tan_out_if.source res_out
);
    localparam int MW   = 2 * COORD_BITS + 2;
    localparam int SDW1 = 3 * MW + 4;
    localparam int SDW2 = SDW1 + K_BITS;
    localparam int SDW3 = AREA_BITS + 4;
    localparam int QB   = NORMAL_BITS + 1;
    localparam int NB   = NORMAL_BITS;

    logic en;

    // front
    logic                 f_valid;
    logic [2:0][MW-1:0]   f_mag;
    logic [2:0]           f_neg;
    logic [SQ_BITS-1:0]   f_sum;
    logic [SDW1-1:0]      f_side;

    // normalize
    logic                 n_valid;
    logic [SQ_BITS-1:0]   n_sum;
    logic [K_BITS-1:0]    n_k;
    logic [SDW1-1:0]      n_side;

    // square root chain
    logic                 s_valid [ROOT_BITS+1];
    logic [SQ_BITS-1:0]   s_rad   [ROOT_BITS+1];
    logic [REM_BITS-1:0]  s_rem   [ROOT_BITS+1];
    logic [ROOT_BITS-1:0] s_root  [ROOT_BITS+1];
    logic [SDW2-1:0]      s_side  [ROOT_BITS+1];

    // post root stage
    logic [SDW1-1:0]           r_side;
    logic [K_BITS-1:0]         r_k;
    logic [2:0][MW-1:0]        r_mag;
    logic [2:0]                r_neg;
    logic                      r_degen;
    logic [ROOT_BITS-1:0]      area_full;
    logic [AREA_BITS-1:0]      area_sat;
    logic [2:0][ROOT_BITS-1:0] m_shift;
    logic                      p_valid_reg;
    logic [ROOT_BITS-1:0]      p_den_reg;
    logic [2:0][ROOT_BITS-1:0] p_rem_reg;
    logic [2:0]                p_low_reg;
    logic [SDW3-1:0]           p_side_reg;

    // divide chain
    logic                      d_valid [QB+1];
    logic [ROOT_BITS-1:0]      d_den   [QB+1];
    logic [2:0][ROOT_BITS-1:0] d_rem   [QB+1];
    logic [2:0][QB-1:0]        d_quo   [QB+1];
    logic [SDW3-1:0]           d_side  [QB+1];

    // output
    logic [AREA_BITS-1:0] o_area;
    logic [2:0]           o_neg;
    logic                 o_degen;
    logic [2:0][NB-1:0]   unit_next;
    logic [QB:0]          qp;
    logic [QB-1:0]        mr;
    logic [QB-1:0]        mneg;
    logic                 out_valid_reg;
    logic [AREA_BITS-1:0] area_reg;
    logic [2:0][NB-1:0]   unit_reg;
    logic                 degen_reg;

    assign en           = !out_valid_reg || res_out.ready;
    assign tri_in.ready = en;

    tan_front #(
        .CB (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tri_in.valid),
        .a_x       (tri_in.a_x),
        .a_y       (tri_in.a_y),
        .a_z       (tri_in.a_z),
        .b_x       (tri_in.b_x),
        .b_y       (tri_in.b_y),
        .b_z       (tri_in.b_z),
        .c_x       (tri_in.c_x),
        .c_y       (tri_in.c_y),
        .c_z       (tri_in.c_z),
        .out_valid (f_valid),
        .mag       (f_mag),
        .neg       (f_neg),
        .sum_sq    (f_sum)
    );

    assign f_side = {f_mag, f_neg, (f_sum == '0)};

    tan_norm #(
        .SDW (SDW1)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_sum    (f_sum),
        .in_side   (f_side),
        .out_valid (n_valid),
        .out_sum   (n_sum),
        .out_k     (n_k),
        .out_side  (n_side)
    );

    assign s_valid[0] = n_valid;
    assign s_rad[0]   = n_sum;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;
    assign s_side[0]  = {n_k, n_side};

    for (genvar j = 0; j < ROOT_BITS; j++)
    begin : g_sqrt
        tan_sqrt_cell #(
            .BIT (ROOT_BITS - 1 - j),
            .SDW (SDW2)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (s_valid[j]),
            .in_rad    (s_rad[j]),
            .in_rem    (s_rem[j]),
            .in_root   (s_root[j]),
            .in_side   (s_side[j]),
            .out_valid (s_valid[j+1]),
            .out_rad   (s_rad[j+1]),
            .out_rem   (s_rem[j+1]),
            .out_root  (s_root[j+1]),
            .out_side  (s_side[j+1])
        );
    end

    always_comb
    begin
        {r_k, r_side}          = s_side[ROOT_BITS];
        {r_mag, r_neg, r_degen} = r_side;
        area_full = s_root[ROOT_BITS] >> ({1'b0, r_k} + (K_BITS + 1)'(1));
        area_sat  = (area_full[ROOT_BITS-1:AREA_BITS] != '0) ? '1
                  : area_full[AREA_BITS-1:0];
        for (int i = 0; i < 3; i++)
        begin
            m_shift[i] = ROOT_BITS'(r_mag[i]) << r_k;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= s_valid[ROOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_den_reg <= s_root[ROOT_BITS];
            for (int i = 0; i < 3; i++)
            begin
                p_rem_reg[i] <= m_shift[i] >> 1;
                p_low_reg[i] <= m_shift[i][0];
            end
            p_side_reg <= {area_sat, r_neg, r_degen};
        end
    end

    assign d_valid[0] = p_valid_reg;
    assign d_den[0]   = p_den_reg;
    assign d_rem[0]   = p_rem_reg;
    assign d_quo[0]   = '0;
    assign d_side[0]  = p_side_reg;

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        tan_div_cell #(
            .QB    (QB),
            .FIRST (j == 0),
            .SDW   (SDW3)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (d_valid[j]),
            .in_den    (d_den[j]),
            .in_rem    (d_rem[j]),
            .in_low    (p_low_reg),
            .in_quo    (d_quo[j]),
            .in_side   (d_side[j]),
            .out_valid (d_valid[j+1]),
            .out_den   (d_den[j+1]),
            .out_rem   (d_rem[j+1]),
            .out_quo   (d_quo[j+1]),
            .out_side  (d_side[j+1])
        );
    end

    // round half away from zero, then sign; positive lanes saturate, degenerate lanes are zero
    always_comb
    begin
        {o_area, o_neg, o_degen} = d_side[QB];
        unit_next = '0;
        qp   = '0;
        mr   = '0;
        mneg = '0;
        for (int i = 0; i < 3; i++)
        begin
            qp   = {1'b0, d_quo[QB][i]} + (QB + 1)'(1);
            mr   = qp[QB:1];
            mneg = ~mr + QB'(1);
            if (o_degen)
            begin
                unit_next[i] = '0;
            end
            else if (o_neg[i])
            begin
                unit_next[i] = mneg[NB-1:0];
            end
            else if (mr > {2'b00, {(NB-1){1'b1}}})
            begin
                unit_next[i] = {1'b0, {(NB-1){1'b1}}};
            end
            else
            begin
                unit_next[i] = mr[NB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            area_reg  <= o_degen ? '0 : o_area;
            unit_reg  <= unit_next;
            degen_reg <= o_degen;
        end
    end

    assign res_out.valid      = out_valid_reg;
    assign res_out.area       = area_reg;
    assign res_out.unit_x     = unit_reg[0];
    assign res_out.unit_y     = unit_reg[1];
    assign res_out.unit_z     = unit_reg[2];
    assign res_out.degenerate = degen_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tan_front.sv =====
// front pipeline: edges, cross product, magnitudes and sum of squares
// depends on tan_pkg
`timescale 1ns / 1ps
`default_nettype none

module tan_front
    import tan_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CB-1:0] a_x,
    input  logic signed [CB-1:0] a_y,
    input  logic signed [CB-1:0] a_z,
    input  logic signed [CB-1:0] b_x,
    input  logic signed [CB-1:0] b_y,
    input  logic signed [CB-1:0] b_z,
    input  logic signed [CB-1:0] c_x,
    input  logic signed [CB-1:0] c_y,
    input  logic signed [CB-1:0] c_z,
    output logic                 out_valid,
    output logic [2:0][2*CB+1:0] mag,
    output logic [2:0]           neg,
    output logic [SQ_BITS-1:0]   sum_sq
);
    localparam int EW  = CB + 1;
    localparam int PW  = 2 * EW;
    localparam int XW  = PW + 1;
    localparam int MW  = 2 * CB + 2;
    localparam int HW  = MW / 2;
    localparam int SQW = 2 * MW;

    logic [FRONT_STAGES-1:0] v_reg;

    logic signed [EW-1:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [PW-1:0] p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;
    logic signed [XW-1:0] cx, cy, cz;
    logic [2:0][MW-1:0]   mag_next;
    logic [2:0]           neg_next;
    logic [2:0][MW-1:0]   mag3_reg, mag4_reg, mag5_reg, mag6_reg;
    logic [2:0]           neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic [2:0][MW-1:0]   ll_reg, lh_reg, hh_reg;
    logic [2:0][SQW-1:0]  sq_reg;
    logic [SQ_BITS-1:0]   sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_comb
    begin
        cx = XW'(p_yz_reg) - XW'(p_zy_reg);
        cy = XW'(p_zx_reg) - XW'(p_xz_reg);
        cz = XW'(p_xy_reg) - XW'(p_yx_reg);
        neg_next = {cz[XW-1], cy[XW-1], cx[XW-1]};
        mag_next[0] = cx[XW-1] ? MW'(-cx) : MW'(cx);
        mag_next[1] = cy[XW-1] ? MW'(-cy) : MW'(cy);
        mag_next[2] = cz[XW-1] ? MW'(-cz) : MW'(cz);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // edges from the first vertex
            e1x_reg <= EW'(b_x) - EW'(a_x);
            e1y_reg <= EW'(b_y) - EW'(a_y);
            e1z_reg <= EW'(b_z) - EW'(a_z);
            e2x_reg <= EW'(c_x) - EW'(a_x);
            e2y_reg <= EW'(c_y) - EW'(a_y);
            e2z_reg <= EW'(c_z) - EW'(a_z);
            // cross product terms
            p_yz_reg <= e1y_reg * e2z_reg;
            p_zy_reg <= e1z_reg * e2y_reg;
            p_zx_reg <= e1z_reg * e2x_reg;
            p_xz_reg <= e1x_reg * e2z_reg;
            p_xy_reg <= e1x_reg * e2y_reg;
            p_yx_reg <= e1y_reg * e2x_reg;
            mag3_reg <= mag_next;
            neg3_reg <= neg_next;
            // split squares
            for (int i = 0; i < 3; i++)
            begin
                ll_reg[i] <= mag3_reg[i][HW-1:0] * mag3_reg[i][HW-1:0];
                lh_reg[i] <= mag3_reg[i][HW-1:0] * mag3_reg[i][MW-1:HW];
                hh_reg[i] <= mag3_reg[i][MW-1:HW] * mag3_reg[i][MW-1:HW];
                sq_reg[i] <= (SQW'(hh_reg[i]) << MW) + (SQW'(lh_reg[i]) << (HW + 1))
                             + SQW'(ll_reg[i]);
            end
            mag4_reg <= mag3_reg;
            neg4_reg <= neg3_reg;
            mag5_reg <= mag4_reg;
            neg5_reg <= neg4_reg;
            sum_reg  <= SQ_BITS'(sq_reg[0]) + SQ_BITS'(sq_reg[1]) + SQ_BITS'(sq_reg[2]);
            mag6_reg <= mag5_reg;
            neg6_reg <= neg5_reg;
        end
    end

    assign out_valid = v_reg[FRONT_STAGES-1];
    assign mag       = mag6_reg;
    assign neg       = neg6_reg;
    assign sum_sq    = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tan_norm.sv =====
// even left shift of the sum of squares, one power-of-two step per stage
// depends on tan_pkg
`timescale 1ns / 1ps
`default_nettype none

module tan_norm
    import tan_pkg::*;
#(
    parameter int SDW = 8
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [SQ_BITS-1:0] in_sum,
    input  logic [SDW-1:0]     in_side,
    output logic               out_valid,
    output logic [SQ_BITS-1:0] out_sum,
    output logic [K_BITS-1:0]  out_k,
    output logic [SDW-1:0]     out_side
);
    logic [NORM_STEPS-1:0] v_reg;
    logic [SQ_BITS-1:0]    s_reg    [NORM_STEPS];
    logic [K_BITS-1:0]     k_reg    [NORM_STEPS];
    logic [SDW-1:0]        side_reg [NORM_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NORM_STEPS-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < NORM_STEPS; i++)
    begin : g_step
        localparam int SH = (SQ_BITS / 2) >> i;
        logic [SQ_BITS-1:0] s_cur;
        logic [K_BITS-1:0]  k_cur;
        logic [SDW-1:0]     side_cur;

        if (i == 0)
        begin : g_first
            assign s_cur    = in_sum;
            assign k_cur    = '0;
            assign side_cur = in_side;
        end
        else
        begin : g_rest
            assign s_cur    = s_reg[i-1];
            assign k_cur    = k_reg[i-1];
            assign side_cur = side_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (s_cur[SQ_BITS-1 -: SH] == '0)
                begin
                    s_reg[i] <= s_cur << SH;
                    k_reg[i] <= k_cur + K_BITS'(SH / 2);
                end
                else
                begin
                    s_reg[i] <= s_cur;
                    k_reg[i] <= k_cur;
                end
                side_reg[i] <= side_cur;
            end
        end
    end

    assign out_valid = v_reg[NORM_STEPS-1];
    assign out_sum   = s_reg[NORM_STEPS-1];
    assign out_k     = k_reg[NORM_STEPS-1];
    assign out_side  = side_reg[NORM_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/tan_sqrt_cell.sv =====
// one root bit of the integer square root, restoring form
// depends on tan_pkg
`timescale 1ns / 1ps
`default_nettype none

module tan_sqrt_cell
    import tan_pkg::*;
#(
    parameter int BIT = 63,
    parameter int SDW = 8
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [SQ_BITS-1:0]   in_rad,
    input  logic [REM_BITS-1:0]  in_rem,
    input  logic [ROOT_BITS-1:0] in_root,
    input  logic [SDW-1:0]       in_side,
    output logic                 out_valid,
    output logic [SQ_BITS-1:0]   out_rad,
    output logic [REM_BITS-1:0]  out_rem,
    output logic [ROOT_BITS-1:0] out_root,
    output logic [SDW-1:0]       out_side
);
    logic                 v_reg;
    logic [SQ_BITS-1:0]   rad_reg;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;
    logic [SDW-1:0]       side_reg;
    logic [REM_BITS-1:0]  cur, trial;
    logic                 ge;

    always_comb
    begin
        cur       = {in_rem[REM_BITS-3:0], in_rad[2*BIT+1 -: 2]};
        trial     = {in_root, 2'b01};
        ge        = (cur >= trial);
        rem_next  = ge ? (cur - trial) : cur;
        root_next = {in_root[ROOT_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= in_rad;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = v_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tan_div_cell.sv =====
// one quotient bit for the three normal lanes, restoring division
// depends on tan_pkg
`timescale 1ns / 1ps
`default_nettype none

module tan_div_cell
    import tan_pkg::*;
#(
    parameter int QB    = 17,
    parameter bit FIRST = 1'b0,
    parameter int SDW   = 8
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [ROOT_BITS-1:0]      in_den,
    input  logic [2:0][ROOT_BITS-1:0] in_rem,
    input  logic [2:0]                in_low,
    input  logic [2:0][QB-1:0]        in_quo,
    input  logic [SDW-1:0]            in_side,
    output logic                      out_valid,
    output logic [ROOT_BITS-1:0]      out_den,
    output logic [2:0][ROOT_BITS-1:0] out_rem,
    output logic [2:0][QB-1:0]        out_quo,
    output logic [SDW-1:0]            out_side
);
    logic                      v_reg;
    logic [ROOT_BITS-1:0]      den_reg;
    logic [2:0][ROOT_BITS-1:0] rem_reg, rem_next;
    logic [2:0][QB-1:0]        quo_reg, quo_next;
    logic [SDW-1:0]            side_reg;
    logic [ROOT_BITS:0]        t;
    logic                      ge;

    always_comb
    begin
        rem_next = '0;
        quo_next = '0;
        t        = '0;
        ge       = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            t  = {in_rem[i], FIRST ? in_low[i] : 1'b0};
            ge = (t >= {1'b0, in_den});
            rem_next[i] = ge ? ROOT_BITS'(t - {1'b0, in_den}) : t[ROOT_BITS-1:0];
            quo_next[i] = {in_quo[i][QB-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= in_den;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = v_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tan_checker.sv =====
// port level checks for triangle_area_and_normal, bound to the top level
// depends on tan_pkg and the top level's channel interfaces
`timescale 1ns / 1ps
`default_nettype none

module tan_checker
    import tan_pkg::*;
#(
    parameter int NB = NORMAL_BITS_DEF
)(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [AREA_BITS-1:0] area,
    input logic [NB-1:0]        unit_x,
    input logic [NB-1:0]        unit_y,
    input logic [NB-1:0]        unit_z,
    input logic                 degenerate
);
    // ready follows the output register
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(in_valid))
        else $error("input valid unknown");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |->
        (area == '0 && unit_x == '0 && unit_y == '0 && unit_z == '0))
        else $error("degenerate result with nonzero fields");

    a_normal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !degenerate) |-> (unit_x != '0 || unit_y != '0 || unit_z != '0))
        else $error("zero normal on a proper triangle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(area) && $stable(unit_x) && $stable(unit_y) &&
         $stable(unit_z) && $stable(degenerate)))
        else $error("stalled result changed");

endmodule

bind triangle_area_and_normal tan_checker #(
    .NB (NORMAL_BITS)
) u_tan_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (tri_in.valid),
    .in_ready   (tri_in.ready),
    .out_valid  (res_out.valid),
    .out_ready  (res_out.ready),
    .area       (res_out.area),
    .unit_x     (res_out.unit_x),
    .unit_y     (res_out.unit_y),
    .unit_z     (res_out.unit_z),
    .degenerate (res_out.degenerate)
);

`default_nettype wire
